// ===== rtl/bba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Beat types, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int SIZE_WIDTH = 7;
   localparam int ADDR_WIDTH = 6;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_ROOM   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  opcode;
      logic [SIZE_WIDTH-1:0]   request_size;
      logic [ADDR_WIDTH-1:0]   block_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]   result_address;
      status_type              status;
   } rsp_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_START,
      FSM_ROOT,
      FSM_DESCEND,
      FSM_CLIMB,
      FSM_UPDATE,
      FSM_RESP
   } fsm_type;

endpackage
`default_nettype wire

// ===== rtl/bba_tree_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy tree memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bba_tree_mem #(
   parameter int DEPTH = 127,
   parameter int AW    = 7,
   parameter int DW    = 7
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over POOL_UNITS units (a power of two). The req
// channel carries one beat per request: allocate a block of request_size
// units, or free the block that starts at block_address. The rsp channel
// returns one beat per request with the block address and a status code.
// The tree of largest free sizes lives in one memory with one read and one
// write port; the controller walks one tree level per cycle through the
// read port, down the tree and back up to the root.
// Paths: an allocate walks down the tree to a block of the wanted size and
// back up to the root; a whole-pool or no-room allocate ends at the root,
// an oversize allocate does not read the tree, and a free climbs from its
// leaf to the allocated block and, if it finds it, on up to the root. One
// request is in work at a time, and req_ready returns in the same cycle
// that rsp_valid rises.
// Reset: a clearing pass writes every tree node with req_ready low.
// Afterwards the whole pool is free.
// Stall: a finished result waits in the output register; the block still
// accepts and works the next request and holds it at the end until rsp is
// taken.
// ----------------------------------------------------------------------------
module buddy_block_allocator #(
   parameter int POOL_UNITS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bba_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bba_pkg::rsp_type      rsp_data
);

   localparam int LOG2   = $clog2(POOL_UNITS);
   localparam int NODES  = 2 * POOL_UNITS - 1;
   localparam int NW     = LOG2 + 1;
   localparam int VW     = LOG2 + 1;
   localparam int AW     = LOG2;
   localparam int OUT_AW = bba_pkg::ADDR_WIDTH;

   function automatic logic [NW-1:0] sib_of(input logic [NW-1:0] n);
      return n[0] ? n + NW'(1) : n - NW'(1);
   endfunction

   bba_pkg::fsm_type            state_ff, state_in;
   bba_pkg::op_type             op_ff, op_in;
   logic [bba_pkg::SIZE_WIDTH-1:0] size_ff, size_in;
   logic [bba_pkg::ADDR_WIDTH-1:0] baddr_ff, baddr_in;
   logic [NW-1:0]               node_ff, node_in;
   logic [VW-1:0]               ns_ff, ns_in;
   logic [VW-1:0]               cur_ff, cur_in;
   logic [AW-1:0]               addr_ff, addr_in;
   logic [AW-1:0]               res_addr_ff, res_addr_in;
   bba_pkg::status_type         res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bba_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic          mem_rd_en;
   logic [NW-1:0] mem_rd_addr;
   logic [VW-1:0] mem_rd_data;
   logic          mem_wr_en;
   logic [NW-1:0] mem_wr_addr;
   logic [VW-1:0] mem_wr_data;

   logic          accept;
   logic          rsp_free;
   logic [VW-1:0] want_c;
   logic          too_large_c;
   logic          outside_c;
   logic [NW-1:0] leaf_c;
   logic [NW-1:0] left_c;
   logic [NW-1:0] right_c;
   logic          go_left_c;
   logic [NW-1:0] child_c;
   logic [VW-1:0] child_ns_c;
   logic [AW-1:0] child_addr_c;
   logic [NW-1:0] parent_c;
   logic [VW:0]   sum_c;
   logic [VW:0]   dbl_c;
   logic [VW-1:0] max_c;
   logic [VW-1:0] merged_c;
   logic          fits_c;
   logic [NW:0]   clr_next_c;
   logic          clr_halve_c;
   logic          clr_last_c;

   bba_tree_mem #(
      .DEPTH (NODES),
      .AW    (NW),
      .DW    (VW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   assign req_ready = (state_ff == bba_pkg::FSM_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      want_c = VW'(POOL_UNITS);
      for (int k = LOG2; k >= 0; k--) begin
         if ((32'd1 << k) >= 32'(size_ff)) begin
            want_c = VW'(32'd1 << k);
         end
      end
   end

   assign too_large_c  = int'(size_ff) > POOL_UNITS;
   assign outside_c    = int'(baddr_ff) >= POOL_UNITS;
   assign leaf_c       = NW'(int'(baddr_ff) + POOL_UNITS - 1);
   assign left_c       = {node_ff[NW-2:0], 1'b1};
   assign right_c      = left_c + NW'(1);
   assign go_left_c    = mem_rd_data >= want_c;
   assign child_c      = go_left_c ? left_c : right_c;
   assign child_ns_c   = ns_ff >> 1;
   assign child_addr_c = go_left_c ? addr_ff : addr_ff + AW'(child_ns_c);
   assign parent_c     = (node_ff - NW'(1)) >> 1;
   assign sum_c        = {1'b0, cur_ff} + {1'b0, mem_rd_data};
   assign dbl_c        = {ns_ff, 1'b0};
   assign max_c        = (cur_ff > mem_rd_data) ? cur_ff : mem_rd_data;
   assign merged_c     = (op_ff == bba_pkg::OP_FREE && sum_c == dbl_c) ? VW'(dbl_c) : max_c;
   assign fits_c       = ((addr_ff & AW'(ns_ff - VW'(1))) == '0)
                         && (int'(ns_ff) >= int'(size_ff));
   assign clr_next_c   = {1'b0, node_ff} + (NW+1)'(1);
   assign clr_halve_c  = ((clr_next_c + (NW+1)'(1)) & clr_next_c) == '0;
   assign clr_last_c   = node_ff == NW'(NODES - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bba_pkg::FSM_CLEAR: begin
            if (clr_last_c) state_in = bba_pkg::FSM_IDLE;
         end
         bba_pkg::FSM_IDLE: begin
            if (accept) state_in = bba_pkg::FSM_START;
         end
         bba_pkg::FSM_START: begin
            if (op_ff == bba_pkg::OP_ALLOC) begin
               state_in = too_large_c ? bba_pkg::FSM_RESP : bba_pkg::FSM_ROOT;
            end else begin
               state_in = outside_c ? bba_pkg::FSM_RESP : bba_pkg::FSM_CLIMB;
            end
         end
         bba_pkg::FSM_ROOT: begin
            if (mem_rd_data < want_c || ns_ff == want_c) begin
               state_in = bba_pkg::FSM_RESP;
            end else begin
               state_in = bba_pkg::FSM_DESCEND;
            end
         end
         bba_pkg::FSM_DESCEND: begin
            if (child_ns_c == want_c) state_in = bba_pkg::FSM_UPDATE;
         end
         bba_pkg::FSM_CLIMB: begin
            if (mem_rd_data != '0) begin
               if (node_ff == '0) state_in = bba_pkg::FSM_RESP;
            end else if (!fits_c || node_ff == '0) begin
               state_in = bba_pkg::FSM_RESP;
            end else begin
               state_in = bba_pkg::FSM_UPDATE;
            end
         end
         bba_pkg::FSM_UPDATE: begin
            if (parent_c == '0) state_in = bba_pkg::FSM_RESP;
         end
         bba_pkg::FSM_RESP: begin
            if (rsp_free) state_in = bba_pkg::FSM_IDLE;
         end
         default: state_in = bba_pkg::FSM_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in         = op_ff;
      size_in       = size_ff;
      baddr_in      = baddr_ff;
      node_in       = node_ff;
      ns_in         = ns_ff;
      cur_in        = cur_ff;
      addr_in       = addr_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = node_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = node_ff;
      mem_wr_data   = ns_ff;
      unique case (state_ff)
         bba_pkg::FSM_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = node_ff;
            mem_wr_data = ns_ff;
            node_in     = NW'(clr_next_c);
            if (clr_halve_c) ns_in = ns_ff >> 1;
         end
         bba_pkg::FSM_IDLE: begin
            if (accept) begin
               op_in    = req_data.opcode;
               size_in  = req_data.request_size;
               baddr_in = req_data.block_address;
            end
         end
         bba_pkg::FSM_START: begin
            res_addr_in = '0;
            if (op_ff == bba_pkg::OP_ALLOC) begin
               if (too_large_c) begin
                  res_status_in = bba_pkg::ST_TOO_LARGE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  node_in     = '0;
                  ns_in       = VW'(POOL_UNITS);
                  addr_in     = '0;
               end
            end else begin
               if (outside_c) begin
                  res_status_in = bba_pkg::ST_NOT_FOUND;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = leaf_c;
                  node_in     = leaf_c;
                  ns_in       = VW'(1);
                  addr_in     = AW'(baddr_ff);
               end
            end
         end
         bba_pkg::FSM_ROOT: begin
            if (mem_rd_data < want_c) begin
               res_status_in = bba_pkg::ST_NO_ROOM;
            end else if (ns_ff == want_c) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = '0;
               mem_wr_data   = '0;
               res_status_in = bba_pkg::ST_OK;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = left_c;
            end
         end
         bba_pkg::FSM_DESCEND: begin
            node_in = child_c;
            ns_in   = child_ns_c;
            addr_in = child_addr_c;
            if (child_ns_c == want_c) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = child_c;
               mem_wr_data = '0;
               cur_in      = '0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = sib_of(child_c);
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = {child_c[NW-2:0], 1'b1};
            end
         end
         bba_pkg::FSM_CLIMB: begin
            if (mem_rd_data != '0) begin
               if (node_ff == '0) begin
                  res_status_in = bba_pkg::ST_NOT_FOUND;
               end else begin
                  node_in     = parent_c;
                  ns_in       = ns_ff << 1;
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = parent_c;
               end
            end else if (!fits_c) begin
               res_status_in = bba_pkg::ST_NOT_FOUND;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = node_ff;
               mem_wr_data = ns_ff;
               cur_in      = ns_ff;
               if (node_ff == '0) begin
                  res_addr_in   = addr_ff;
                  res_status_in = bba_pkg::ST_OK;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = sib_of(node_ff);
               end
            end
         end
         bba_pkg::FSM_UPDATE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = parent_c;
            mem_wr_data = merged_c;
            node_in     = parent_c;
            cur_in      = merged_c;
            ns_in       = ns_ff << 1;
            if (parent_c == '0) begin
               res_addr_in   = addr_ff;
               res_status_in = bba_pkg::ST_OK;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = sib_of(parent_c);
            end
         end
         bba_pkg::FSM_RESP: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_address = OUT_AW'(res_addr_ff);
               rsp_data_in.status         = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::FSM_CLEAR;
         node_ff      <= '0;
         ns_ff        <= VW'(POOL_UNITS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_ff      <= node_in;
         ns_ff        <= ns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      baddr_ff      <= baddr_in;
      cur_ff        <= cur_in;
      addr_ff       <= addr_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free beats with random gaps on req, stalls rsp at
// random, and checks every response beat against a shadow copy of the
// largest-free tree kept in a small scoreboard class. A directed opening
// covers the boundary sizes and every status code; the random part keeps a
// list of live blocks so most frees hit real allocations.
// ----------------------------------------------------------------------------
module testbench;

   localparam int POOL         = 64;
   localparam int NODES        = 2 * POOL - 1;
   localparam int RANDOM_ITEMS = 750;
   localparam int STALL_LIMIT  = 3000;

   class buddy_tracker;
      int unsigned      largest_free[NODES];
      bba_pkg::rsp_type pending_rsp[$];
      int unsigned      live_addr[$];
      int unsigned      live_size[$];
      int               errors;
      int               noted;
      int               checked;
      int               status_seen[4];

      function new();
         int unsigned ns;
         ns = 2 * POOL;
         for (int unsigned i = 0; i < NODES; i++) begin
            if (((i + 1) & i) == 0) ns = ns >> 1;
            largest_free[i] = ns;
         end
      endfunction

      function bba_pkg::rsp_type grab_block(int unsigned req);
         bba_pkg::rsp_type rsp;
         int unsigned      want;
         int unsigned      node;
         int unsigned      ns;
         int unsigned      left;
         int unsigned      addr;
         rsp.result_address = '0;
         want = 1;
         node = 0;
         ns   = POOL;
         if (req > POOL) begin
            rsp.status = bba_pkg::ST_TOO_LARGE;
            return rsp;
         end
         while (want < req) want = want << 1;
         if (largest_free[0] < want) begin
            rsp.status = bba_pkg::ST_NO_ROOM;
            return rsp;
         end
         while (ns > want) begin
            left = 2 * node + 1;
            node = (largest_free[left] >= want) ? left : left + 1;
            ns   = ns >> 1;
         end
         largest_free[node] = 0;
         addr = (node + 1) * ns - POOL;
         while (node > 0) begin
            node = (node - 1) / 2;
            largest_free[node] = (largest_free[2*node+1] > largest_free[2*node+2]) ?
                                 largest_free[2*node+1] : largest_free[2*node+2];
         end
         live_addr.push_back(addr);
         live_size.push_back(want);
         rsp.result_address = addr[bba_pkg::ADDR_WIDTH-1:0];
         rsp.status = bba_pkg::ST_OK;
         return rsp;
      endfunction

      function bba_pkg::rsp_type release_block(int unsigned req, int unsigned addr);
         bba_pkg::rsp_type rsp;
         int unsigned      node;
         int unsigned      ns;
         int unsigned      l;
         int unsigned      r;
         rsp.result_address = '0;
         rsp.status = bba_pkg::ST_NOT_FOUND;
         ns = 1;
         if (addr >= POOL) return rsp;
         node = addr + POOL - 1;
         while (largest_free[node] != 0) begin
            if (node == 0) return rsp;
            node = (node - 1) / 2;
            ns   = ns << 1;
         end
         if ((node + 1) * ns - POOL != addr || ns < req) return rsp;
         largest_free[node] = ns;
         while (node > 0) begin
            node = (node - 1) / 2;
            ns   = ns << 1;
            l    = largest_free[2*node+1];
            r    = largest_free[2*node+2];
            largest_free[node] = (l + r == ns) ? ns : ((l > r) ? l : r);
         end
         for (int i = 0; i < live_addr.size(); i++) begin
            if (live_addr[i] == addr) begin
               live_addr.delete(i);
               live_size.delete(i);
               break;
            end
         end
         rsp.result_address = addr[bba_pkg::ADDR_WIDTH-1:0];
         rsp.status = bba_pkg::ST_OK;
         return rsp;
      endfunction

      function void note_request(bba_pkg::req_type item);
         bba_pkg::rsp_type rsp;
         if (item.opcode == bba_pkg::OP_ALLOC) rsp = grab_block(item.request_size);
         else rsp = release_block(item.request_size, item.block_address);
         pending_rsp.push_back(rsp);
         status_seen[rsp.status]++;
         noted++;
      endfunction

      function void check_response(bba_pkg::rsp_type got);
         bba_pkg::rsp_type exp;
         checked++;
         if (pending_rsp.size() == 0) begin
            $error("response beat with nothing pending: result_address %0d, status %0d",
                   got.result_address, got.status);
            errors++;
            return;
         end
         exp = pending_rsp.pop_front();
         if (got.result_address !== exp.result_address) begin
            $error("result_address: expected %0d, actual %0d",
                   exp.result_address, got.result_address);
            errors++;
         end
         if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bba_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bba_pkg::rsp_type rsp_data;
   logic             steady    = 1'b0;
   int               idle_cycles = 0;

   buddy_tracker board = new();

   buddy_block_allocator #(
      .POOL_UNITS (POOL)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
      rsp_ready <= steady || ($urandom_range(99) >= 32);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d responses pending",
                  idle_cycles, board.pending_rsp.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic bba_pkg::req_type make_req(bba_pkg::op_type op, int unsigned size,
                                                 int unsigned addr);
      bba_pkg::req_type item;
      item.opcode        = op;
      item.request_size  = bba_pkg::SIZE_WIDTH'(size);
      item.block_address = bba_pkg::ADDR_WIDTH'(addr);
      return item;
   endfunction

   function automatic bba_pkg::req_type next_random_request();
      bba_pkg::req_type item;
      int unsigned      pick;
      int unsigned      idx;
      int unsigned      bsize;
      int unsigned      size_pick;
      item = make_req(bba_pkg::OP_ALLOC, 1, $urandom_range(POOL - 1));
      pick = $urandom_range(99);
      if (pick < 45 || (pick < 85 && board.live_addr.size() == 0)) begin
         size_pick = $urandom_range(99);
         if (size_pick < 70)
            item.request_size = bba_pkg::SIZE_WIDTH'($urandom_range(8, 1));
         else if (size_pick < 90)
            item.request_size = bba_pkg::SIZE_WIDTH'($urandom_range(64, 9));
         else if (size_pick < 95)
            item.request_size = '0;
         else
            item.request_size = bba_pkg::SIZE_WIDTH'($urandom_range(127, 65));
      end else if (pick < 85) begin
         idx   = $urandom_range(board.live_addr.size() - 1);
         bsize = board.live_size[idx];
         item.opcode        = bba_pkg::OP_FREE;
         item.block_address = bba_pkg::ADDR_WIDTH'(board.live_addr[idx]);
         if ($urandom_range(9) == 0)
            item.request_size = bba_pkg::SIZE_WIDTH'($urandom_range(127, bsize + 1));
         else
            item.request_size = bba_pkg::SIZE_WIDTH'($urandom_range(bsize, 0));
      end else begin
         item.opcode       = bba_pkg::OP_FREE;
         item.request_size = bba_pkg::SIZE_WIDTH'($urandom_range(127, 0));
         if (board.live_addr.size() != 0 && $urandom_range(1) == 1) begin
            idx = $urandom_range(board.live_addr.size() - 1);
            item.block_address = bba_pkg::ADDR_WIDTH'(board.live_addr[idx] +
                                 $urandom_range(board.live_size[idx], 1));
         end
      end
      return item;
   endfunction

   task automatic send_request(input bba_pkg::req_type item, input bit calm);
      int unsigned gap;
      gap = 0;
      if (!calm) while ($urandom_range(99) < 32) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   initial begin
      int unsigned k;
      bit          calm;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_req(bba_pkg::OP_ALLOC, 64, 0), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 1, 0), 0);
      send_request(make_req(bba_pkg::OP_FREE, 1, 5), 0);
      send_request(make_req(bba_pkg::OP_FREE, 127, 0), 0);
      send_request(make_req(bba_pkg::OP_FREE, 0, 0), 0);
      send_request(make_req(bba_pkg::OP_FREE, 1, 0), 0);
      send_request(make_req(bba_pkg::OP_FREE, 0, 42), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 0, 21), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 65, 0), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 127, 63), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 3, 0), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 32, 0), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 16, 0), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 33, 0), 0);
      send_request(make_req(bba_pkg::OP_FREE, 5, 4), 0);
      send_request(make_req(bba_pkg::OP_FREE, 4, 4), 0);
      send_request(make_req(bba_pkg::OP_FREE, 1, 63), 0);
      send_request(make_req(bba_pkg::OP_FREE, 32, 32), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 2, 0), 0);
      send_request(make_req(bba_pkg::OP_FREE, 1, 0), 0);
      send_request(make_req(bba_pkg::OP_FREE, 2, 2), 0);
      send_request(make_req(bba_pkg::OP_FREE, 16, 16), 0);
      send_request(make_req(bba_pkg::OP_ALLOC, 1, 63), 0);
      send_request(make_req(bba_pkg::OP_FREE, 1, 0), 0);

      for (k = 0; k < RANDOM_ITEMS; k++) begin
         calm = (k >= 300 && k < 420);
         steady <= calm;
         send_request(next_random_request(), calm);
      end
      req_valid <= 1'b0;
      steady    <= 1'b0;

      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d allocate/free beats, checked %0d response beats",
               board.noted, board.checked);
      $display("Statuses: ok %0d, too large %0d, no room %0d, not found %0d",
               board.status_seen[bba_pkg::ST_OK], board.status_seen[bba_pkg::ST_TOO_LARGE],
               board.status_seen[bba_pkg::ST_NO_ROOM],
               board.status_seen[bba_pkg::ST_NOT_FOUND]);
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// ===== buddy_block_allocator.f =====
rtl/bba_pkg.sv
rtl/bba_tree_mem.sv
rtl/buddy_block_allocator.sv
test/testbench.sv
